// ----- hdl/sps_pkg.sv -----
// Shared types, codes and coil tables for the stepper phase sequencer.
// No dependencies; the top level imports it.
package sps_pkg;

    localparam int unsigned MAX_FULL_STEPS = 1024;
    localparam int unsigned MIN_FULL_STEPS = 4;
    localparam int unsigned SPR_W          = 11;  // full_steps_per_rev field
    localparam int unsigned POS_W          = 11;  // step position
    localparam int unsigned REV_W          = 12;  // doubled revolution length
    localparam int unsigned CFG_IDX_W      = 1;

    typedef enum logic [1:0] {
        MODE_HALF  = 2'd0,
        MODE_FULL1 = 2'd1,
        MODE_FULL2 = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_STEP = 2'd0,
        FUNC_GOTO = 2'd1,
        FUNC_TICK = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_MODE = 1'd0,
        CFG_FULL_SPR  = 1'd1
    } t_cfg_idx;

    localparam logic [POS_W-1:0] SPR_RESET = POS_W'(200);

    // Coil pattern for a phase index in the given mode.
    function automatic logic [3:0] coil_entry(input t_mode mode, input logic [2:0] idx);
        logic [3:0] pat;
        begin
            case (mode)
                MODE_HALF: begin
                    case (idx)
                        3'd0:    pat = 4'h9;
                        3'd1:    pat = 4'h8;
                        3'd2:    pat = 4'hA;
                        3'd3:    pat = 4'h2;
                        3'd4:    pat = 4'h6;
                        3'd5:    pat = 4'h4;
                        3'd6:    pat = 4'h5;
                        default: pat = 4'h1;
                    endcase
                end
                MODE_FULL1: begin
                    case (idx[1:0])
                        2'd0:    pat = 4'h8;
                        2'd1:    pat = 4'h2;
                        2'd2:    pat = 4'h4;
                        default: pat = 4'h1;
                    endcase
                end
                default: begin
                    case (idx[1:0])
                        2'd0:    pat = 4'h9;
                        2'd1:    pat = 4'hA;
                        2'd2:    pat = 4'h6;
                        default: pat = 4'h5;
                    endcase
                end
            endcase
            return pat;
        end
    endfunction

    // Last phase index of the active table.
    function automatic logic [2:0] table_last(input t_mode mode);
        return (mode == MODE_HALF) ? 3'd7 : 3'd3;
    endfunction

endpackage

// ----- hdl/stepper_phase_sequencer.sv -----
// Top level of the stepper phase sequencer: command register, step logic
// and result register with flow control. Depends on sps_pkg.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------
//  in      | input     | i_in_valid/o_in_stall   | func, direction, quadrant
//  out     | output    | o_out_valid/i_out_stall | coil_pattern, position,
//          |           |                     | stepped, moving
//  cfg     | input     | i_cfg_valid/o_cfg_ready | register index, data
//
// A word is taken into the command register on the edge it is accepted and
// its result is written to the result register once it is processed, which
// an output stall can delay. One word can be accepted every cycle while the
// output does not stall, a rate set by the phase and position register loop.
// Reset is synchronous and active low; it sets half-step mode, 200 full
// steps, phase index 7 with pattern 0x1, position 0 and no armed goto.
// An output stall holds the result; the command register keeps taking words
// while it is empty or its word can move to the result register, so stalls do not drop data.
module stepper_phase_sequencer
    import sps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic                 i_direction,
    input  logic [1:0]           i_quadrant,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [3:0]           o_coil_pattern,
    output logic [POS_W-1:0]     o_position,
    output logic                 o_stepped,
    output logic                 o_moving,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SPR_W-1:0]     i_cfg_data
);

    // Configuration registers.
    t_mode            r_mode, n_mode;
    logic [SPR_W-1:0] r_spr, n_spr;

    // Motor state.
    logic [2:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_coil, n_coil;
    logic             r_armed, n_armed;
    logic             r_gdir, n_gdir;
    logic [POS_W-1:0] r_target, n_target;

    // Command register.
    logic             r_cmd_valid;
    logic [1:0]       r_func;
    logic             r_dir;
    logic [1:0]       r_quad;

    // Result register.
    logic             r_out_valid;
    logic [3:0]       r_out_coil;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_stepped;
    logic             r_out_moving;

    logic             exec;       // command register word is processed
    logic             cmd_load;   // command register takes a new word
    logic             cfg_wr;
    logic             n_stepped;

    // Revolution length and step helpers.
    logic [SPR_W-1:0] spr_sat;
    logic [REV_W-1:0] rev;
    logic [REV_W-1:0] quarter_x3;
    logic [REV_W-1:0] goto_pos;
    logic [2:0]       last;
    logic [2:0]       idx;
    logic             sdir;
    logic [2:0]       step_idx;
    logic [POS_W-1:0] step_pos;
    logic [REV_W-1:0] pos_inc;

    assign exec     = r_cmd_valid && (!r_out_valid || !i_out_stall);
    assign cmd_load = !r_cmd_valid || exec;
    assign cfg_wr   = i_cfg_valid;

    assign o_in_stall  = r_cmd_valid && !exec;
    assign o_cfg_ready = 1'b1;

    // Saturate the revolution size, then double it in half-step mode.
    always_comb begin
        if (r_spr < SPR_W'(MIN_FULL_STEPS)) begin
            spr_sat = SPR_W'(MIN_FULL_STEPS);
        end else if (r_spr > SPR_W'(MAX_FULL_STEPS)) begin
            spr_sat = SPR_W'(MAX_FULL_STEPS);
        end else begin
            spr_sat = r_spr;
        end
        rev = (r_mode == MODE_HALF) ? {spr_sat, 1'b0} : {1'b0, spr_sat};
    end

    // Goto target is a quarter revolution times the quadrant, built by shifts and an add.
    always_comb begin
        quarter_x3 = {2'b00, rev[REV_W-1:2]} + {1'b0, rev[REV_W-1:2], 1'b0};
        case (r_quad)
            2'd0:    goto_pos = '0;
            2'd1:    goto_pos = {2'b00, rev[REV_W-1:2]};
            2'd2:    goto_pos = {1'b0, rev[REV_W-1:2], 1'b0};
            default: goto_pos = quarter_x3;
        endcase
    end

    // One step in the chosen direction. Clockwise moves the phase index back
    // and the position forward; a position past the revolution end snaps to
    // zero going clockwise and to the last step going anticlockwise.
    always_comb begin
        last    = table_last(r_mode);
        idx     = r_phase & last;
        sdir    = (r_func == FUNC_STEP) ? r_dir : r_gdir;
        pos_inc = {1'b0, r_pos} + REV_W'(1);
        if (!sdir) begin
            step_idx = (idx == 3'd0) ? last : idx - 3'd1;
            step_pos = (pos_inc >= rev) ? '0 : pos_inc[POS_W-1:0];
        end else begin
            step_idx = (idx >= last) ? 3'd0 : idx + 3'd1;
            if (r_pos == '0 || {1'b0, r_pos} >= rev) begin
                step_pos = POS_W'(rev - REV_W'(1));
            end else begin
                step_pos = r_pos - POS_W'(1);
            end
        end
    end

    // Next state for configuration writes and commands. The user must write only
    // while the block is idle; the block does not enforce it, and a write wins over a command.
    always_comb begin
        n_mode    = r_mode;
        n_spr     = r_spr;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_coil    = r_coil;
        n_armed   = r_armed;
        n_gdir    = r_gdir;
        n_target  = r_target;
        n_stepped = 1'b0;
        if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_MODE: begin
                    // Mode code three runs as two-phase full step.
                    n_mode  = (i_cfg_data[1:0] == 2'd3) ? MODE_FULL2 : t_mode'(i_cfg_data[1:0]);
                    n_phase = table_last(n_mode);
                    n_coil  = coil_entry(n_mode, n_phase);
                    n_armed = 1'b0;
                end
                CFG_FULL_SPR: begin
                    n_spr   = i_cfg_data;
                    n_armed = 1'b0;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end else if (exec) begin
            case (t_func'(r_func))
                FUNC_STEP: begin
                    n_stepped = 1'b1;
                end
                FUNC_GOTO: begin
                    n_target = goto_pos[POS_W-1:0];
                    n_gdir   = r_dir;
                    n_armed  = (r_pos != goto_pos[POS_W-1:0]);
                end
                FUNC_TICK: begin
                    // Armed always means not yet at target, so a tick steps.
                    if (r_armed) begin
                        if (r_pos == r_target) begin
                            n_armed = 1'b0;
                        end else begin
                            n_stepped = 1'b1;
                        end
                    end
                end
                default: begin
                    n_stepped = 1'b0;
                end
            endcase
            if (n_stepped) begin
                n_phase = step_idx;
                n_pos   = step_pos;
                n_coil  = coil_entry(r_mode, step_idx);
                if (r_armed && step_pos == r_target) begin
                    n_armed = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HALF;
            r_spr       <= SPR_RESET;
            r_phase     <= 3'd7;
            r_pos       <= '0;
            r_coil      <= 4'h1;
            r_armed     <= 1'b0;
            r_gdir      <= 1'b0;
            r_target    <= '0;
            r_cmd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_spr    <= n_spr;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_coil   <= n_coil;
            r_armed  <= n_armed;
            r_gdir   <= n_gdir;
            r_target <= n_target;
            if (cmd_load) begin
                r_cmd_valid <= i_in_valid;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (cmd_load) begin
            r_func <= i_func;
            r_dir  <= i_direction;
            r_quad <= i_quadrant;
        end
        if (exec) begin
            r_out_coil    <= n_coil;
            r_out_pos     <= n_pos;
            r_out_stepped <= n_stepped;
            r_out_moving  <= n_armed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_out_coil;
    assign o_position     = r_out_pos;
    assign o_stepped      = r_out_stepped;
    assign o_moving       = r_out_moving;

    // The coil drive always matches the table entry at the phase index.
    a_coil_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coil == coil_entry(r_mode, r_phase))
        else $error("coil drive does not match phase table entry");

    // Full-step tables only ever use the low four phase indexes.
    a_full_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_HALF) |-> (r_phase[2] == 1'b0))
        else $error("phase index beyond full-step table");

    // An armed goto is never sitting on its target.
    a_armed_off_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_pos != r_target))
        else $error("goto armed while at target");

    // A processed command with a pending stalled result cannot happen.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !exec)
        else $error("result register overwritten while stalled");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the stepper phase sequencer: a directed table,
// then randomized command words, checked against typed-in results or a behavioral predictor.
// Depends on sps_pkg and the stepper_phase_sequencer top level.
module testbench;
    import sps_pkg::*;

    // Function code 3 has no name in the package; the block must ignore it.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic       DIR_CW    = 1'b0;
    localparam logic       DIR_CCW   = 1'b1;

    // Coil tables packed one nibble per phase index, index 0 in the low nibble.
    localparam logic [31:0] HALF_SEQ  = 32'h1546_2A89;
    localparam logic [15:0] FULL1_SEQ = 16'h1428;
    localparam logic [15:0] FULL2_SEQ = 16'h56A9;

    // Cycles without any handshake before the run is declared hung. The longest
    // legitimate quiet stretch is the long receiver hold of HOLD_CYCLES.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;

    // One result word as the block reports it.
    typedef struct packed {
        logic [3:0]       coil;
        logic [POS_W-1:0] pos;
        logic             stepped;
        logic             moving;
    } t_drive;

    // One row of the directed table: either a register write or a command word,
    // the latter optionally with its result typed in.
    typedef struct packed {
        bit               is_cfg;
        t_cfg_idx         idx;
        logic [SPR_W-1:0] data;
        logic [1:0]       func;
        logic             dir;
        logic [1:0]       quad;
        bit               typed;
        t_drive           want;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_func      = FUNC_STEP;
    logic                 i_direction = DIR_CW;
    logic [1:0]           i_quadrant  = 2'd0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [3:0]           o_coil_pattern;
    logic [POS_W-1:0]     o_position;
    logic                 o_stepped;
    logic                 o_moving;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_STEP_MODE;
    logic [SPR_W-1:0]     i_cfg_data  = '0;

    stepper_phase_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_direction    (i_direction),
        .i_quadrant     (i_quadrant),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coil_pattern (o_coil_pattern),
        .o_position     (o_position),
        .o_stepped      (o_stepped),
        .o_moving       (o_moving),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predicted motor state, updated as words and register writes are accepted.
    t_mode            cur_mode;
    logic [SPR_W-1:0] cur_spr;
    logic [2:0]       cur_phase;
    logic [POS_W-1:0] cur_pos;
    logic [3:0]       cur_coil;
    logic             goto_on;
    logic             goto_way;
    logic [POS_W-1:0] goto_at;

    // Results owed by the block, oldest first.
    t_drive due_results[$];

    int error_count   = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int next_hold_at  = 300;

    function automatic logic [2:0] last_phase();
        return (cur_mode == MODE_HALF) ? 3'd7 : 3'd3;
    endfunction

    function automatic logic [3:0] pattern_at(input logic [2:0] idx);
        case (cur_mode)
            MODE_HALF:  return HALF_SEQ[idx*4 +: 4];
            MODE_FULL1: return FULL1_SEQ[idx[1:0]*4 +: 4];
            default:    return FULL2_SEQ[idx[1:0]*4 +: 4];
        endcase
    endfunction

    // Steps in one revolution: the register saturated to its legal range,
    // doubled in half-step mode.
    function automatic logic [REV_W-1:0] rev_len();
        logic [REV_W-1:0] r;
        r = REV_W'(cur_spr);
        if (r < REV_W'(MIN_FULL_STEPS)) r = REV_W'(MIN_FULL_STEPS);
        if (r > REV_W'(MAX_FULL_STEPS)) r = REV_W'(MAX_FULL_STEPS);
        return (cur_mode == MODE_HALF) ? (r << 1) : r;
    endfunction

    function automatic void load_last_phase();
        cur_phase = last_phase();
        cur_coil  = pattern_at(cur_phase);
    endfunction

    // Clockwise walks the table backward and the position forward. A position
    // left beyond the revolution by a register write snaps to 0 going clockwise
    // and to the last step going anticlockwise.
    function automatic void take_one_step(input logic way);
        logic [2:0]       last;
        logic [REV_W-1:0] rev;
        logic [2:0]       idx;
        last = last_phase();
        rev  = rev_len();
        idx  = cur_phase & last;
        if (way == DIR_CW) begin
            idx     = (idx == 3'd0) ? last : idx - 3'd1;
            cur_pos = (REV_W'(cur_pos) + 1 >= rev) ? '0 : cur_pos + 1'b1;
        end else begin
            idx = (idx >= last) ? 3'd0 : idx + 3'd1;
            if (cur_pos == '0 || REV_W'(cur_pos) >= rev) begin
                cur_pos = POS_W'(rev - 1);
            end else begin
                cur_pos = cur_pos - 1'b1;
            end
        end
        cur_phase = idx;
        cur_coil  = pattern_at(idx);
        // Any step that lands on an armed target ends the goto.
        if (goto_on && cur_pos == goto_at) goto_on = 1'b0;
    endfunction

    // Advances the predicted motor by one command word and returns its result.
    function automatic t_drive next_drive(input logic [1:0] func, input logic way,
                                          input logic [1:0] quad);
        t_drive d;
        d.stepped = 1'b0;
        case (func)
            FUNC_STEP: begin
                take_one_step(way);
                d.stepped = 1'b1;
            end
            FUNC_GOTO: begin
                goto_at  = POS_W'((rev_len() >> 2) * quad);
                goto_way = way;
                goto_on  = (cur_pos != goto_at);
            end
            FUNC_TICK: begin
                if (goto_on) begin
                    if (cur_pos == goto_at) begin
                        goto_on = 1'b0;
                    end else begin
                        take_one_step(goto_way);
                        d.stepped = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        d.coil   = cur_coil;
        d.pos    = cur_pos;
        d.moving = goto_on;
        return d;
    endfunction

    // Either register write drops an armed goto; a mode write also reloads the
    // last entry of the new table. Mode code 3 behaves as two-phase full step.
    function automatic void apply_reg(input t_cfg_idx idx, input logic [SPR_W-1:0] data);
        if (idx == CFG_STEP_MODE) begin
            cur_mode = (data[1:0] == 2'd3) ? MODE_FULL2 : t_mode'(data[1:0]);
            load_last_phase();
        end else begin
            cur_spr = data;
        end
        goto_on = 1'b0;
    endfunction

    function automatic t_row word_row(input logic [1:0] func, input logic way,
                                      input logic [1:0] quad);
        t_row r;
        r      = '0;
        r.func = func;
        r.dir  = way;
        r.quad = quad;
        return r;
    endfunction

    function automatic t_row known_row(input logic [1:0] func, input logic way,
                                       input logic [1:0] quad, input logic [3:0] coil,
                                       input int pos, input logic st, input logic mv);
        t_row r;
        r       = word_row(func, way, quad);
        r.typed = 1'b1;
        r.want  = '{coil, POS_W'(pos), st, mv};
        return r;
    endfunction

    function automatic t_row reg_row(input t_cfg_idx idx, input logic [SPR_W-1:0] data);
        t_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    // Offers one command word, idling at random first, and holds it until the
    // block takes it. Valid stays high on return so back-to-back words need no
    // second assignment in the same step.
    task automatic send_word(input logic [1:0] func, input logic way, input logic [1:0] quad,
                             input bit typed, input t_drive want);
        t_drive got;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_direction <= way;
        i_quadrant  <= quad;
        do @(posedge i_clk); while (o_in_stall);
        got = next_drive(func, way, quad);
        due_results.push_back(typed ? want : got);
    endtask

    // Stops offering words and waits until every owed result has come back,
    // then lets the two-stage pipeline go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SPR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Result side: checks each accepted word against the oldest expectation,
    // then decides the stall for the next cycle. Every 600 results or so it
    // holds the block off for a long stretch so the pipeline fills and the
    // input side has to stall.
    always @(posedge i_clk) begin
        t_drive want;
        if (o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word, coil %h position %0d stepped %b moving %b",
                         $time, o_coil_pattern, o_position, o_stepped, o_moving);
                error_count++;
            end else begin
                want = due_results.pop_front();
                check_field("coil_pattern", POS_W'(want.coil), POS_W'(o_coil_pattern));
                check_field("position", want.pos, o_position);
                check_field("stepped", POS_W'(want.stepped), POS_W'(o_stepped));
                check_field("moving", POS_W'(want.moving), POS_W'(o_moving));
            end
            results_seen++;
        end
        if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row             script[$];
        t_row             r;
        int               words;
        int               n;
        int               pick;
        bit               paused;
        logic [1:0]       func;
        logic [1:0]       mode_code;
        logic [SPR_W-1:0] mode_data;
        logic [SPR_W-1:0] spr_data;

        // The predictor starts from the reset state of the block.
        cur_mode = MODE_HALF;
        cur_spr  = SPR_RESET;
        cur_pos  = '0;
        goto_on  = 1'b0;
        goto_way = DIR_CW;
        goto_at  = '0;
        load_last_phase();

        // Directed part. Results are typed in only for the first few words after
        // reset, where the state is obvious; the rest go through the predictor.
        script = '{
            // Fresh from reset: half step, phase 7 driving 0x1, position 0.
            known_row(FUNC_TICK, DIR_CW, 2'd0, 4'h1, 0, 1'b0, 1'b0),
            known_row(FUNC_NONE, DIR_CCW, 2'd3, 4'h1, 0, 1'b0, 1'b0),
            known_row(FUNC_STEP, DIR_CW, 2'd0, 4'h5, 1, 1'b1, 1'b0),
            known_row(FUNC_STEP, DIR_CCW, 2'd0, 4'h1, 0, 1'b1, 1'b0),
            // Anticlockwise from 0 wraps to the last of 400 half steps.
            known_row(FUNC_STEP, DIR_CCW, 2'd0, 4'h9, 399, 1'b1, 1'b0),
            word_row(FUNC_GOTO, DIR_CW, 2'd0),
            word_row(FUNC_TICK, DIR_CW, 2'd0),
            word_row(FUNC_TICK, DIR_CCW, 2'd1),
            // Goto to where the motor already is does not arm.
            word_row(FUNC_GOTO, DIR_CCW, 2'd0),
            // Size below range saturates to 4; mode code 3 acts as two-phase.
            reg_row(CFG_FULL_SPR, 11'd0),
            reg_row(CFG_STEP_MODE, 11'h7FF),
            word_row(FUNC_GOTO, DIR_CCW, 2'd1),
            // A single step onto the armed target disarms it.
            word_row(FUNC_STEP, DIR_CW, 2'd0),
            word_row(FUNC_GOTO, DIR_CW, 2'd3),
            word_row(FUNC_TICK, DIR_CCW, 2'd2),
            // Size above range saturates; the write also drops the goto.
            reg_row(CFG_FULL_SPR, 11'h7FF),
            word_row(FUNC_TICK, DIR_CW, 2'd0),
            reg_row(CFG_STEP_MODE, SPR_W'(MODE_HALF)),
            word_row(FUNC_STEP, DIR_CCW, 2'd0),
            word_row(FUNC_STEP, DIR_CCW, 2'd0),
            word_row(FUNC_STEP, DIR_CCW, 2'd0),
            // Position 2047 is now far beyond a 10-step revolution.
            reg_row(CFG_FULL_SPR, 11'd5),
            word_row(FUNC_STEP, DIR_CCW, 2'd0),
            // Shrinking to 5 full steps leaves position 9 beyond the end again.
            reg_row(CFG_STEP_MODE, SPR_W'(MODE_FULL1)),
            word_row(FUNC_STEP, DIR_CW, 2'd0),
            word_row(FUNC_GOTO, DIR_CW, 2'd3),
            word_row(FUNC_TICK, DIR_CW, 2'd0),
            word_row(FUNC_TICK, DIR_CW, 2'd0),
            word_row(FUNC_TICK, DIR_CW, 2'd0),
            word_row(FUNC_TICK, DIR_CW, 2'd0)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles a little and the receiver a lot for the first phases.
        send_idle_pct = 19;
        recv_idle_pct = 56;

        foreach (script[k]) begin
            r = script[k];
            if (r.is_cfg) begin
                settle();
                write_reg(r.idx, r.data);
            end else begin
                send_word(r.func, r.dir, r.quad, r.typed, r.want);
            end
        end

        // Random phases, each under a fresh configuration written while idle.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 56;
                recv_idle_pct = 19;
            end
            if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();

            // Walk every mode code early on, then pick at random. The upper data
            // bits of the mode register are random noise.
            mode_code = (p < 4) ? 2'(p) : 2'($urandom_range(3));
            mode_data = {9'($urandom_range(511)), mode_code};
            // Mostly small revolutions so gotos finish; exact and out-of-range
            // extremes show up too.
            if (p == 1) begin
                spr_data = 11'd4;
            end else if (p == 5) begin
                spr_data = 11'd1024;
            end else begin
                case ($urandom_range(9))
                    0:       spr_data = 11'($urandom_range(3));
                    1:       spr_data = 11'($urandom_range(2047, 1025));
                    default: spr_data = 11'($urandom_range(48, 5));
                endcase
            end
            if ($urandom_range(1) == 1) begin
                write_reg(CFG_STEP_MODE, mode_data);
                write_reg(CFG_FULL_SPR, spr_data);
            end else begin
                write_reg(CFG_FULL_SPR, spr_data);
                write_reg(CFG_STEP_MODE, mode_data);
            end

            words  = 0;
            paused = 1'b0;
            while (words < PHASE_WORDS) begin
                // Now and then the sender stops until everything owed is back.
                if (!paused && words >= PHASE_WORDS / 2 && p % 3 == 1) begin
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 12) begin
                    // Armed goto followed by a run of ticks, the normal usage.
                    send_word(FUNC_GOTO, 1'($urandom_range(1)), 2'($urandom_range(3)),
                              1'b0, '0);
                    n = $urandom_range(40, 2);
                    repeat (n) send_word(FUNC_TICK, 1'($urandom_range(1)),
                                         2'($urandom_range(3)), 1'b0, '0);
                    words += n + 1;
                end else begin
                    pick = $urandom_range(99);
                    func = (pick < 35) ? FUNC_STEP :
                           (pick < 50) ? FUNC_GOTO :
                           (pick < 92) ? FUNC_TICK : FUNC_NONE;
                    send_word(func, 1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0, '0);
                    if (func != FUNC_NONE) words++;
                end
            end
        end

        // Drain, then give the block time to show any stray word.
        settle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
